### rtl/sctt_pkg.sv
// shared types, constants and codes of the state countdown timer
package sctt_pkg;

    localparam int COUNT_BITS_DEF  = 32;
    localparam int PERIOD_BITS_DEF = 16;

    localparam int STATE_W     = 32;
    localparam int CNT_FIELD_W = 32;
    localparam int PER_FIELD_W = 16;

    localparam int S_TDATA_W = 280;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 104;

    typedef enum logic [2:0] {
        ACT_TICK       = 3'd0,
        ACT_UPDATE     = 3'd1,
        ACT_START_WAIT = 3'd2,
        ACT_END_WAIT   = 3'd3,
        ACT_CLEAR      = 3'd4,
        ACT_PAUSE      = 3'd5,
        ACT_RESUME     = 3'd6,
        ACT_QUERY      = 3'd7
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_LOAD
    } ctrl_state_t;

    typedef struct packed {
        logic exec;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic rem_busy;
    } dp_status_t;

    typedef struct packed {
        action_t                  action;
        logic [STATE_W-1:0]       new_state;
        logic [CNT_FIELD_W-1:0]   wait_ticks;
        logic [CNT_FIELD_W-1:0]   append_ticks;
        logic [CNT_FIELD_W-1:0]   tick_count;
        logic [STATE_W-1:0]       ok_state;
        logic [STATE_W-1:0]       fail_state;
        logic [CNT_FIELD_W-1:0]   ok_ticks;
        logic [CNT_FIELD_W-1:0]   fail_ticks;
        logic                     succeeded;
        logic [PER_FIELD_W-1:0]   period;
        logic                     allow_zero;
    } in_item_t;

    typedef struct packed {
        logic [STATE_W-1:0]       state_word;
        logic [CNT_FIELD_W-1:0]   remaining;
        logic [CNT_FIELD_W-1:0]   elapsed;
        logic                     tick_ended;
        logic                     in_period;
        logic                     is_paused;
        logic                     is_waiting;
    } out_item_t;

endpackage

### rtl/sctt_rem.sv
// bit-serial restoring remainder of the count by the period
module sctt_rem #(
    parameter int COUNT_BITS  = sctt_pkg::COUNT_BITS_DEF,
    parameter int PERIOD_BITS = sctt_pkg::PERIOD_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [COUNT_BITS-1:0]  dividend,
    input  logic [PERIOD_BITS-1:0] divisor,
    output logic                   busy,
    output logic [PERIOD_BITS-1:0] remainder
);
    import sctt_pkg::*;

    localparam int CNT_W = $clog2(COUNT_BITS + 1);

    logic                   busy_reg, busy_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [COUNT_BITS-1:0]  dvd_reg, dvd_next;
    logic [PERIOD_BITS-1:0] div_reg, div_next;
    logic [PERIOD_BITS-1:0] r_reg, r_next;
    logic [PERIOD_BITS:0]   r_shift;
    logic [PERIOD_BITS:0]   r_diff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        div_reg <= div_next;
        r_reg   <= r_next;
    end

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        r_next    = r_reg;
        r_shift   = {r_reg, dvd_reg[COUNT_BITS-1]};
        r_diff    = r_shift - {1'b0, div_reg};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(COUNT_BITS);
            dvd_next  = dividend;
            div_next  = divisor;
            r_next    = '0;
        end
        else if (busy_reg)
        begin
            // one quotient bit per cycle, msb first
            dvd_next = {dvd_reg[COUNT_BITS-2:0], 1'b0};
            if (r_shift >= {1'b0, div_reg})
                r_next = r_diff[PERIOD_BITS-1:0];
            else
                r_next = r_shift[PERIOD_BITS-1:0];
            cnt_next  = cnt_reg - CNT_W'(1);
            busy_next = (cnt_reg != CNT_W'(1));
        end
    end

    assign busy      = busy_reg;
    assign remainder = r_reg;

endmodule

### rtl/sctt_datapath.sv
// timer state registers, command execution and result register
module sctt_datapath #(
    parameter int COUNT_BITS  = sctt_pkg::COUNT_BITS_DEF,
    parameter int PERIOD_BITS = sctt_pkg::PERIOD_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sctt_pkg::ctrl_cmd_t  cmd,
    output sctt_pkg::dp_status_t status,
    input  sctt_pkg::in_item_t   item,
    output sctt_pkg::out_item_t  result
);
    import sctt_pkg::*;

    logic [STATE_W-1:0]     cur_state_reg, cur_state_next;
    logic [COUNT_BITS-1:0]  remaining_reg, remaining_next;
    logic [COUNT_BITS-1:0]  start_reg, start_next;
    logic [STATE_W-1:0]     pend_ok_state_reg, pend_ok_state_next;
    logic [STATE_W-1:0]     pend_fail_state_reg, pend_fail_state_next;
    logic [COUNT_BITS-1:0]  pend_ok_cnt_reg, pend_ok_cnt_next;
    logic [COUNT_BITS-1:0]  pend_fail_cnt_reg, pend_fail_cnt_next;
    logic                   paused_reg, paused_next;
    logic                   waiting_reg, waiting_next;
    logic [PERIOD_BITS-1:0] per_reg, per_next;
    logic                   allow_reg, allow_next;
    out_item_t              result_reg, result_next;

    logic [COUNT_BITS-1:0]  wait_c, append_c, tick_c;
    logic [COUNT_BITS-1:0]  add_a;
    logic [COUNT_BITS:0]    add_sum;
    logic [COUNT_BITS-1:0]  sat_sum;
    logic [COUNT_BITS-1:0]  elapsed_c;
    logic                   rem_busy;
    logic [PERIOD_BITS-1:0] rem_val;

    assign wait_c   = COUNT_BITS'(item.wait_ticks);
    assign append_c = COUNT_BITS'(item.append_ticks);
    assign tick_c   = COUNT_BITS'(item.tick_count);

    // shared saturating adder for update and end of wait
    always_comb
    begin
        if (item.action == ACT_END_WAIT)
            add_a = item.succeeded ? pend_ok_cnt_reg : pend_fail_cnt_reg;
        else
            add_a = wait_c;
        add_sum = {1'b0, add_a} + {1'b0, append_c};
        sat_sum = add_sum[COUNT_BITS] ? '1 : add_sum[COUNT_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_state_reg       <= '0;
            remaining_reg       <= '0;
            start_reg           <= '0;
            pend_ok_state_reg   <= '0;
            pend_fail_state_reg <= '0;
            pend_ok_cnt_reg     <= '0;
            pend_fail_cnt_reg   <= '0;
            paused_reg          <= 1'b0;
            waiting_reg         <= 1'b0;
        end
        else
        begin
            cur_state_reg       <= cur_state_next;
            remaining_reg       <= remaining_next;
            start_reg           <= start_next;
            pend_ok_state_reg   <= pend_ok_state_next;
            pend_fail_state_reg <= pend_fail_state_next;
            pend_ok_cnt_reg     <= pend_ok_cnt_next;
            pend_fail_cnt_reg   <= pend_fail_cnt_next;
            paused_reg          <= paused_next;
            waiting_reg         <= waiting_next;
        end
    end

    always_ff @(posedge clk)
    begin
        per_reg    <= per_next;
        allow_reg  <= allow_next;
        result_reg <= result_next;
    end

    always_comb
    begin
        logic [COUNT_BITS-1:0] after_tick;
        cur_state_next       = cur_state_reg;
        remaining_next       = remaining_reg;
        start_next           = start_reg;
        pend_ok_state_next   = pend_ok_state_reg;
        pend_fail_state_next = pend_fail_state_reg;
        pend_ok_cnt_next     = pend_ok_cnt_reg;
        pend_fail_cnt_next   = pend_fail_cnt_reg;
        paused_next          = paused_reg;
        waiting_next         = waiting_reg;
        per_next             = per_reg;
        allow_next           = allow_reg;
        after_tick = (remaining_reg > tick_c) ? (remaining_reg - tick_c) : '0;
        if (cmd.exec)
        begin
            per_next   = PERIOD_BITS'(item.period);
            allow_next = item.allow_zero;
            case (item.action)
                ACT_TICK:
                begin
                    if (!paused_reg)
                    begin
                        remaining_next = after_tick;
                        // timeout: fail outcome with nothing appended
                        if ((after_tick == '0) && waiting_reg)
                        begin
                            cur_state_next       = pend_fail_state_reg;
                            start_next           = pend_fail_cnt_reg;
                            remaining_next       = pend_fail_cnt_reg;
                            pend_ok_state_next   = '0;
                            pend_fail_state_next = '0;
                            pend_ok_cnt_next     = '0;
                            pend_fail_cnt_next   = '0;
                            waiting_next         = 1'b0;
                        end
                    end
                end
                ACT_UPDATE:
                begin
                    cur_state_next = item.new_state;
                    start_next     = sat_sum;
                    remaining_next = sat_sum;
                end
                ACT_START_WAIT:
                begin
                    start_next           = wait_c;
                    remaining_next       = wait_c;
                    pend_ok_state_next   = item.ok_state;
                    pend_fail_state_next = item.fail_state;
                    pend_ok_cnt_next     = COUNT_BITS'(item.ok_ticks);
                    pend_fail_cnt_next   = COUNT_BITS'(item.fail_ticks);
                    waiting_next         = 1'b1;
                end
                ACT_END_WAIT:
                begin
                    cur_state_next       = item.succeeded ? pend_ok_state_reg
                                                          : pend_fail_state_reg;
                    start_next           = sat_sum;
                    remaining_next       = sat_sum;
                    pend_ok_state_next   = '0;
                    pend_fail_state_next = '0;
                    pend_ok_cnt_next     = '0;
                    pend_fail_cnt_next   = '0;
                    waiting_next         = 1'b0;
                end
                ACT_CLEAR:
                begin
                    cur_state_next       = '0;
                    remaining_next       = '0;
                    start_next           = '0;
                    pend_ok_state_next   = '0;
                    pend_fail_state_next = '0;
                    pend_ok_cnt_next     = '0;
                    pend_fail_cnt_next   = '0;
                    paused_next          = 1'b0;
                    waiting_next         = 1'b0;
                end
                ACT_PAUSE:  paused_next = 1'b1;
                ACT_RESUME: paused_next = 1'b0;
                ACT_QUERY:  ;
                default:    ;
            endcase
        end
    end

    sctt_rem #(
        .COUNT_BITS  (COUNT_BITS),
        .PERIOD_BITS (PERIOD_BITS)
    ) u_rem (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.exec),
        .dividend  (remaining_next),
        .divisor   (per_next),
        .busy      (rem_busy),
        .remainder (rem_val)
    );

    assign elapsed_c = (remaining_reg > start_reg) ? '0 : (start_reg - remaining_reg);

    always_comb
    begin
        result_next = result_reg;
        if (cmd.load_out)
        begin
            result_next.state_word = cur_state_reg;
            result_next.remaining  = CNT_FIELD_W'(remaining_reg);
            result_next.elapsed    = CNT_FIELD_W'(elapsed_c);
            result_next.tick_ended = (remaining_reg == '0);
            result_next.in_period  = (per_reg != '0) && (rem_val == '0) &&
                                     ((remaining_reg != '0) || allow_reg);
            result_next.is_paused  = paused_reg;
            result_next.is_waiting = waiting_reg;
        end
    end

    assign status.rem_busy = rem_busy;
    assign result          = result_reg;

endmodule

### rtl/sctt_ctrl.sv
// controller: handshake, sequencing of execute, remainder and result load
module sctt_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output sctt_pkg::ctrl_cmd_t  cmd,
    input  sctt_pkg::dp_status_t status
);
    import sctt_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd.exec     = 1'b0;
        cmd.load_out = 1'b0;
        s_tready     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.exec   = 1'b1;
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (!status.rem_busy)
                    state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign m_tvalid = out_valid_reg;

endmodule

### rtl/state_countdown_timer_with_timeout_top.sv
// top level of the state countdown timer with timeout
// each request is one command to a timer that keeps a 32-bit state word,
// a saturating down-counter with its start value, a pause flag and one
// pending wait with ok and fail outcomes; every request returns exactly one
// result with the state, remaining count, elapsed count, flags and a check
// of whether the remaining count is a multiple of the request's period.
// one request is handled at a time: the next one is taken only once the
// result of the last is loaded. the command executes on acceptance, then
// a bit-serial remainder unit walks the counter one bit per cycle, the
// controller sees the finished remainder, then the result register is
// loaded. the result register parts the two sides, so the next request
// is taken while a result waits for m_tready; only the load of the
// following result waits for it.
module state_countdown_timer_with_timeout_top #(
    parameter int COUNT_BITS  = sctt_pkg::COUNT_BITS_DEF,
    parameter int PERIOD_BITS = sctt_pkg::PERIOD_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // request channel
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // new_state[31:0], wait_ticks[63:32], append_ticks[95:64],
    // tick_count[127:96], ok_state[159:128], fail_state[191:160],
    // ok_ticks[223:192], fail_ticks[255:224], succeeded[256],
    // period[272:257], allow_zero[273], zero fill[279:274]
    input  logic [sctt_pkg::S_TDATA_W-1:0] s_tdata,
    // action[2:0]
    input  logic [sctt_pkg::S_TUSER_W-1:0] s_tuser,
    // result channel
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // state_word[31:0], remaining[63:32], elapsed[95:64], tick_ended[96],
    // in_period[97], is_paused[98], is_waiting[99], zero fill[103:100]
    output logic [sctt_pkg::M_TDATA_W-1:0] m_tdata
);
    import sctt_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;
    in_item_t   item;
    out_item_t  result;

    // unpack the request fields
    assign item.action       = action_t'(s_tuser);
    assign item.new_state    = s_tdata[31:0];
    assign item.wait_ticks   = s_tdata[63:32];
    assign item.append_ticks = s_tdata[95:64];
    assign item.tick_count   = s_tdata[127:96];
    assign item.ok_state     = s_tdata[159:128];
    assign item.fail_state   = s_tdata[191:160];
    assign item.ok_ticks     = s_tdata[223:192];
    assign item.fail_ticks   = s_tdata[255:224];
    assign item.succeeded    = s_tdata[256];
    assign item.period       = s_tdata[272:257];
    assign item.allow_zero   = s_tdata[273];

    // controller: owns both handshakes
    sctt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    // datapath: timer state, remainder unit and result register
    sctt_datapath #(
        .COUNT_BITS  (COUNT_BITS),
        .PERIOD_BITS (PERIOD_BITS)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .status (status),
        .item   (item),
        .result (result)
    );

    // pack the result fields, zero fill at the top and state word lowest
    assign m_tdata = {4'b0000,
                      result.is_waiting,
                      result.is_paused,
                      result.in_period,
                      result.tick_ended,
                      result.elapsed,
                      result.remaining,
                      result.state_word};

endmodule

### rtl/sctt_checker.sv
// port-level assertions for the timer top level and their bind
module sctt_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [sctt_pkg::M_TDATA_W-1:0] m_tdata
);
    import sctt_pkg::*;

    // stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // stalled result payload is steady
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result payload changed while stalled");

    // one request at a time: busy right after acceptance
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while one is in work");

    // the remainder pass runs first, so no result rises right after a request
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result appeared one cycle after request");

    // ended flag only with a zero remaining field
    a_ended_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[96] |-> (m_tdata[63:32] == 32'd0))
        else $error("tick_ended set with nonzero remaining");

endmodule

bind state_countdown_timer_with_timeout_top sctt_checker u_sctt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### tb/sv/state_countdown_timer_with_timeout_top_tb.sv
// self-checking testbench of the state countdown timer with timeout
module state_countdown_timer_with_timeout_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import sctt_pkg::*;

    // cycles a request may still be in flight after the last result
    localparam int DRAIN_CYCLES  = COUNT_BITS_DEF + 3 + 10;
    localparam int REPORT_LIMIT  = 10;
    localparam int HOLD_CYCLES   = 400;

    logic                   clk;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata  = '0;
    logic [S_TUSER_W-1:0]   s_tuser  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;

    // timer state as the predictor sees it
    logic [STATE_W-1:0]     tmr_state;
    logic [CNT_FIELD_W-1:0] tmr_remaining;
    logic [CNT_FIELD_W-1:0] tmr_start;
    logic [STATE_W-1:0]     pend_ok_state;
    logic [STATE_W-1:0]     pend_fail_state;
    logic [CNT_FIELD_W-1:0] pend_ok_count;
    logic [CNT_FIELD_W-1:0] pend_fail_count;
    logic                   tmr_paused;
    logic                   tmr_waiting;

    // status words still owed by the block, oldest first
    out_item_t              expected_status_q[$];

    int                     src_idle_pct  = 33;
    int                     sink_idle_pct = 69;
    int                     sink_hold_left = 0;
    int                     mismatch_count = 0;

    state_countdown_timer_with_timeout_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // hard stop in case the block hangs
    initial
    begin
        #10_000_000;
        $display("state_countdown_timer_with_timeout_top: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // count sum that sticks at all ones
    function automatic logic [CNT_FIELD_W-1:0] sat_sum(logic [CNT_FIELD_W-1:0] a,
                                                        logic [CNT_FIELD_W-1:0] b);
        logic [CNT_FIELD_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_FIELD_W] ? '1 : s[CNT_FIELD_W-1:0];
    endfunction

    function automatic void clear_timer();
        tmr_state       = '0;
        tmr_remaining   = '0;
        tmr_start       = '0;
        pend_ok_state   = '0;
        pend_fail_state = '0;
        pend_ok_count   = '0;
        pend_fail_count = '0;
        tmr_paused      = 1'b0;
        tmr_waiting     = 1'b0;
    endfunction

    function automatic void load_timer(logic [STATE_W-1:0] st, logic [CNT_FIELD_W-1:0] cnt,
                                       logic [CNT_FIELD_W-1:0] extra);
        tmr_state     = st;
        tmr_start     = sat_sum(cnt, extra);
        tmr_remaining = tmr_start;
    endfunction

    // apply one wait outcome and drop the pending wait, armed or not
    function automatic void close_wait(logic ok, logic [CNT_FIELD_W-1:0] extra);
        if (ok)
            load_timer(pend_ok_state, pend_ok_count, extra);
        else
            load_timer(pend_fail_state, pend_fail_count, extra);
        pend_ok_state   = '0;
        pend_fail_state = '0;
        pend_ok_count   = '0;
        pend_fail_count = '0;
        tmr_waiting     = 1'b0;
    endfunction

    // run one command on the predicted timer and return the status it reports
    function automatic out_item_t predict_status(in_item_t cmd);
        out_item_t              st;
        logic [CNT_FIELD_W-1:0] per;
        case (cmd.action)
            ACT_TICK:
                if (!tmr_paused)
                begin
                    tmr_remaining = (tmr_remaining > cmd.tick_count) ?
                                    tmr_remaining - cmd.tick_count : '0;
                    // timeout fires even when already at zero
                    if (tmr_remaining == '0 && tmr_waiting)
                        close_wait(1'b0, '0);
                end
            ACT_UPDATE:
                load_timer(cmd.new_state, cmd.wait_ticks, cmd.append_ticks);
            ACT_START_WAIT:
            begin
                tmr_start       = cmd.wait_ticks;
                tmr_remaining   = cmd.wait_ticks;
                pend_ok_state   = cmd.ok_state;
                pend_fail_state = cmd.fail_state;
                pend_ok_count   = cmd.ok_ticks;
                pend_fail_count = cmd.fail_ticks;
                tmr_waiting     = 1'b1;
            end
            ACT_END_WAIT:
                close_wait(cmd.succeeded, cmd.append_ticks);
            ACT_CLEAR:
                clear_timer();
            ACT_PAUSE:
                tmr_paused = 1'b1;
            ACT_RESUME:
                tmr_paused = 1'b0;
            default:
                ;
        endcase

        per = {{(CNT_FIELD_W-PER_FIELD_W){1'b0}}, cmd.period};
        if (per == '0)
            st.in_period = 1'b0;
        else if (tmr_remaining == '0 && !cmd.allow_zero)
            st.in_period = 1'b0;
        else
            st.in_period = (tmr_remaining % per) == '0;

        st.state_word = tmr_state;
        st.remaining  = tmr_remaining;
        st.elapsed    = (tmr_remaining > tmr_start) ? '0 : tmr_start - tmr_remaining;
        st.tick_ended = (tmr_remaining == '0);
        st.is_paused  = tmr_paused;
        st.is_waiting = tmr_waiting;
        return st;
    endfunction

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------

    // offer one request, wait for the handshake, then predict its status;
    // tvalid is left high so back-to-back requests never toggle it
    task automatic send_cmd(input in_item_t cmd);
        if ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, cmd.allow_zero, cmd.period, cmd.succeeded,
                     cmd.fail_ticks, cmd.ok_ticks, cmd.fail_state, cmd.ok_state,
                     cmd.tick_count, cmd.append_ticks, cmd.wait_ticks, cmd.new_state};
        s_tuser  <= cmd.action;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_status_q.push_back(predict_status(cmd));
    endtask

    function automatic in_item_t blank_request(action_t act);
        in_item_t c;
        c        = '0;
        c.action = act;
        return c;
    endfunction

    // counts lean small so ticks reach zero and timeouts happen often
    function automatic logic [CNT_FIELD_W-1:0] rand_count();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return 32'hFFFF_FFFF - $urandom_range(3);
            3, 4:    return $urandom;
            default: return $urandom_range(64);
        endcase
    endfunction

    function automatic logic [PER_FIELD_W-1:0] rand_period();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return PER_FIELD_W'($urandom);
            default: return PER_FIELD_W'($urandom_range(1, 12));
        endcase
    endfunction

    function automatic in_item_t rand_cmd();
        in_item_t c;
        int       pick;
        pick = $urandom_range(99);
        if (pick < 40)
            c.action = ACT_TICK;
        else if (pick < 50)
            c.action = ACT_UPDATE;
        else if (pick < 65)
            c.action = ACT_START_WAIT;
        else if (pick < 75)
            c.action = ACT_END_WAIT;
        else if (pick < 79)
            c.action = ACT_CLEAR;
        else if (pick < 85)
            c.action = ACT_PAUSE;
        else if (pick < 93)
            c.action = ACT_RESUME;
        else
            c.action = ACT_QUERY;
        c.new_state    = $urandom;
        c.wait_ticks   = rand_count();
        c.append_ticks = rand_count();
        c.tick_count   = rand_count();
        c.ok_state     = $urandom;
        c.fail_state   = $urandom;
        c.ok_ticks     = rand_count();
        c.fail_ticks   = rand_count();
        c.succeeded    = 1'($urandom_range(1));
        c.period       = rand_period();
        c.allow_zero   = 1'($urandom_range(1));
        return c;
    endfunction

    // ------------------------------------------------------------------
    // result side: random ready, optional long hold-off, and checking
    // ------------------------------------------------------------------

    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("status %s: expected %h, got %h", name, want, got);
        end
    endfunction

    task automatic check_status(input logic [M_TDATA_W-1:0] word);
        out_item_t want;
        if (expected_status_q.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("status with no request outstanding: got %h", word);
        end
        else
        begin
            want = expected_status_q.pop_front();
            compare_field("state_word", want.state_word, word[31:0]);
            compare_field("remaining",  want.remaining,  word[63:32]);
            compare_field("elapsed",    want.elapsed,    word[95:64]);
            compare_field("tick_ended", 32'(want.tick_ended), 32'(word[96]));
            compare_field("in_period",  32'(want.in_period),  32'(word[97]));
            compare_field("is_paused",  32'(want.is_paused),  32'(word[98]));
            compare_field("is_waiting", 32'(want.is_waiting), 32'(word[99]));
        end
    endtask

    always @(posedge clk)
    begin
        if (m_tvalid === 1'b1 && m_tready)
            check_status(m_tdata);
        // a hold-off keeps ready low for a counted stretch
        if (sink_hold_left > 0)
        begin
            m_tready       <= 1'b0;
            sink_hold_left = sink_hold_left - 1;
        end
        else
            m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // status straight after reset, period check at zero count
    task automatic test_idle_status();
        in_item_t c;
        c = blank_request(ACT_QUERY);
        send_cmd(c);
        c.period     = 16'd1;
        c.allow_zero = 1'b1;
        send_cmd(c);
    endtask

    // loads, saturation, ticks down to zero
    task automatic test_load_and_countdown();
        in_item_t c;
        c              = blank_request(ACT_UPDATE);
        c.new_state    = '1;
        c.wait_ticks   = '1;
        c.append_ticks = 32'd1;
        c.period       = '1;
        c.allow_zero   = 1'b1;
        send_cmd(c);
        c            = blank_request(ACT_TICK);
        c.period     = 16'd1;
        send_cmd(c);
        c.tick_count = 32'hFFFF_FFFE;
        send_cmd(c);
        c              = blank_request(ACT_UPDATE);
        c.new_state    = 32'h0000_0005;
        c.wait_ticks   = 32'd100;
        c.append_ticks = 32'd20;
        c.period       = 16'd7;
        send_cmd(c);
        c            = blank_request(ACT_TICK);
        c.tick_count = 32'd20;
        c.period     = 16'd10;
        send_cmd(c);
        c.tick_count = '1;
        c.period     = 16'd1;
        send_cmd(c);
    endtask

    // ticks are ignored while paused, other commands still act
    task automatic test_pause_resume();
        in_item_t c;
        c = blank_request(ACT_PAUSE);
        send_cmd(c);
        c              = blank_request(ACT_UPDATE);
        c.new_state    = 32'hA5A5_5A5A;
        c.wait_ticks   = 32'd9;
        send_cmd(c);
        c            = blank_request(ACT_TICK);
        c.tick_count = 32'd5;
        send_cmd(c);
        c = blank_request(ACT_RESUME);
        send_cmd(c);
        c            = blank_request(ACT_TICK);
        c.tick_count = 32'd3;
        c.period     = 16'd3;
        send_cmd(c);
    endtask

    // ok and fail ends, end with nothing armed, replacement and timeouts
    task automatic test_wait_outcomes();
        in_item_t c;
        c            = blank_request(ACT_START_WAIT);
        c.wait_ticks = 32'd10;
        c.ok_state   = 32'h0000_00AA;
        c.fail_state = 32'h0000_00BB;
        c.ok_ticks   = 32'd50;
        c.fail_ticks = 32'd7;
        send_cmd(c);
        c            = blank_request(ACT_TICK);
        c.tick_count = 32'd4;
        send_cmd(c);
        c              = blank_request(ACT_END_WAIT);
        c.succeeded    = 1'b1;
        c.append_ticks = '1;
        send_cmd(c);
        // nothing armed: pending values were cleared by the last end
        c              = blank_request(ACT_END_WAIT);
        c.append_ticks = 32'd3;
        send_cmd(c);
        c            = blank_request(ACT_START_WAIT);
        c.wait_ticks = 32'd8;
        c.ok_ticks   = 32'd1;
        send_cmd(c);
        // a second start replaces the pending wait
        c            = blank_request(ACT_START_WAIT);
        c.wait_ticks = 32'd5;
        c.ok_state   = '1;
        c.fail_state = 32'h1234_5678;
        c.ok_ticks   = 32'd2;
        c.fail_ticks = '1;
        send_cmd(c);
        c            = blank_request(ACT_TICK);
        send_cmd(c);
        // timeout applies the fail outcome
        c.tick_count = 32'd9;
        c.period     = '1;
        c.allow_zero = 1'b1;
        send_cmd(c);
        c            = blank_request(ACT_START_WAIT);
        c.fail_state = 32'h0000_0077;
        c.fail_ticks = 32'd12;
        send_cmd(c);
        // zero tick on an already-zero count still times out
        c = blank_request(ACT_TICK);
        send_cmd(c);
        c              = blank_request(ACT_END_WAIT);
        c.append_ticks = 32'd4;
        send_cmd(c);
    endtask

    // clear drops every entry, the pause flag included
    task automatic test_clear();
        in_item_t c;
        c = blank_request(ACT_PAUSE);
        send_cmd(c);
        c            = blank_request(ACT_START_WAIT);
        c.wait_ticks = 32'd30;
        c.ok_ticks   = 32'd6;
        send_cmd(c);
        c = blank_request(ACT_CLEAR);
        send_cmd(c);
        c              = blank_request(ACT_END_WAIT);
        c.succeeded    = 1'b1;
        c.append_ticks = 32'd2;
        send_cmd(c);
    endtask

    task automatic test_random_commands(input int count);
        repeat (count)
            send_cmd(rand_cmd());
    endtask

    // receiver stalls for a long stretch while requests keep coming
    task automatic test_output_backpressure();
        sink_hold_left = HOLD_CYCLES;
        repeat (12)
            send_cmd(rand_cmd());
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial
    begin
        clear_timer();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sender idles a third of the time, receiver two thirds
        test_idle_status();
        test_load_and_countdown();
        test_pause_resume();
        test_wait_outcomes();
        test_clear();
        test_random_commands(680);

        // swap the idle rates
        src_idle_pct  = 69;
        sink_idle_pct = 33;
        test_random_commands(650);
        test_output_backpressure();

        // full rate on both sides
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        test_random_commands(650);

        s_tvalid <= 1'b0;
        while (expected_status_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("state_countdown_timer_with_timeout_top: match");
        else
            $display("state_countdown_timer_with_timeout_top: mismatch");
        $finish;
    end

endmodule
